FILE: design/venturi_pressure_flow_meter_unit_macros.svh
// Assertion macros shared by the flow meter modules.
`ifndef VENTURI_PRESSURE_FLOW_METER_UNIT_MACROS_SVH
`define VENTURI_PRESSURE_FLOW_METER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPFM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/vpfm_pkg.sv
// Shared types, widths, reset values and helper functions of the flow meter.
package vpfm_pkg;

	localparam int COUNT_W     = 14;
	localparam int GAIN_W      = 24;
	localparam int THR_W       = 16;
	localparam int PRES_W      = 20;
	localparam int FLOW_W      = 16;
	localparam int SUM_W       = 26;
	localparam int CNT_MAX_W   = 6;
	localparam int STATUS_W    = 2;
	localparam int ACTION_W    = 2;
	localparam int BYTE_W      = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int ROUND_SHIFT = 16;
	localparam int PROD_W      = COUNT_W + GAIN_W;
	localparam int RND_W       = PROD_W - ROUND_SHIFT + 1;
	localparam int RAW_W       = RND_W + 1;
	localparam int OPND_W      = SUM_W - 1;
	localparam int REM_W       = 14;
	localparam int ROOT_W      = PRES_W / 2;
	localparam int SQRT_STEPS  = PRES_W / 2;
	localparam int DIV_STEPS   = OPND_W;
	localparam int STEP_W      = 5;

	localparam int ZERO_SAMPLES_DEF = 32;

	localparam logic [COUNT_W-1:0] COUNT_OFFSET_RST   = 14'd8192;
	localparam logic [GAIN_W-1:0]  PRESSURE_GAIN_RST  = 24'd2547816;
	localparam logic [THR_W-1:0]   FLOW_THRESHOLD_RST = 16'd256;
	localparam logic [GAIN_W-1:0]  CFM_GAIN_RST       = 24'd1850540;
	localparam logic [GAIN_W-1:0]  M3H_GAIN_RST       = 24'd3144090;

	typedef enum logic [ACTION_W-1:0] {
		ACT_MEASURE = 2'd0,
		ACT_SAMPLE  = 2'd1,
		ACT_COMMIT  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT_OFFSET   = 3'd0,
		REG_PRESSURE_GAIN  = 3'd1,
		REG_FLOW_THRESHOLD = 3'd2,
		REG_CFM_GAIN       = 3'd3,
		REG_M3H_GAIN       = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_RAW,
		S_PRES,
		S_CHECK,
		S_ROOT,
		S_MUL_C,
		S_MUL_M,
		S_FLOW_M,
		S_DIV,
		S_DONE
	} state_t;

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} iu_op_t;

	typedef struct packed {
		logic   start;
		iu_op_t op;
	} iu_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} iu_stat_t;

	// Clamp a wide signed value into the pressure range.
	function automatic logic signed [PRES_W-1:0] sat_pres(input logic signed [RAW_W:0] v);
		logic [RAW_W-PRES_W+1:0] hi;
		hi = v[RAW_W:PRES_W-1];
		if (hi == '0 || hi == '1) begin
			return v[PRES_W-1:0];
		end else if (v[RAW_W]) begin
			return {1'b1, {(PRES_W-1){1'b0}}};
		end else begin
			return {1'b0, {(PRES_W-1){1'b1}}};
		end
	endfunction

	// Clamp a rounded product to the flow range.
	function automatic logic [FLOW_W-1:0] sat_flow(input logic [RND_W-1:0] v);
		if (|v[RND_W-1:FLOW_W]) begin
			return '1;
		end else begin
			return v[FLOW_W-1:0];
		end
	endfunction

endpackage

FILE: design/vpfm_if.sv
// Handshake channels of the flow meter: sensor requests, results, register writes.
interface vpfm_in_if;
	import vpfm_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic                read_ok;
	logic [BYTE_W-1:0]   byte_high;
	logic [BYTE_W-1:0]   byte_low;
	modport source (output valid, action, read_ok, byte_high, byte_low, input ready);
	modport sink (input valid, action, read_ok, byte_high, byte_low, output ready);
endinterface

interface vpfm_out_if;
	import vpfm_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     read_valid;
	logic [STATUS_W-1:0]      sensor_status;
	logic signed [PRES_W-1:0] pressure;
	logic [FLOW_W-1:0]        flow_cfm;
	logic [FLOW_W-1:0]        flow_m3h;
	logic                     zero_failed;
	modport source (output valid, read_valid, sensor_status, pressure, flow_cfm, flow_m3h,
		zero_failed, input ready);
	modport sink (input valid, read_valid, sensor_status, pressure, flow_cfm, flow_m3h,
		zero_failed, output ready);
endinterface

interface vpfm_cfg_if;
	import vpfm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/vpfm_mul.sv
// Registered multiplier with round-half-up by 2^16.
module vpfm_mul (
	input  logic                          clk,
	input  logic                          start,
	input  logic [vpfm_pkg::COUNT_W-1:0]  a,
	input  logic [vpfm_pkg::GAIN_W-1:0]   b,
	output logic [vpfm_pkg::RND_W-1:0]    rnd
);
	import vpfm_pkg::*;

	localparam logic [PROD_W:0] HALF = (PROD_W+1)'(2 ** (ROUND_SHIFT - 1));

	logic [PROD_W-1:0] prod_q;
	logic [PROD_W:0]   sum;

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign sum = {1'b0, prod_q} + HALF;
	assign rnd = sum[PROD_W:ROUND_SHIFT];

endmodule

FILE: design/vpfm_iu.sv
// Shared compare-subtract unit: digit-by-digit square root and restoring division.
`include "venturi_pressure_flow_meter_unit_macros.svh"

module vpfm_iu (
	input  logic                            clk,
	input  logic                            arst_n,
	input  vpfm_pkg::iu_req_t               req,
	input  logic [vpfm_pkg::OPND_W-1:0]     opnd,
	input  logic [vpfm_pkg::CNT_MAX_W-1:0]  dvsr,
	output vpfm_pkg::iu_stat_t              stat,
	output logic [vpfm_pkg::OPND_W-1:0]     result
);
	import vpfm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	iu_op_t               op_q;
	logic [STEP_W-1:0]    step_q;
	logic [OPND_W-1:0]    src_q;
	logic [REM_W-1:0]     rem_q;
	logic [OPND_W-1:0]    res_q;
	logic [CNT_MAX_W-1:0] dvsr_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             fits;

	// sqrt brings down two bits per step against 4r+1, divide one bit against the divisor
	always_comb begin
		if (op_q == OP_SQRT) begin
			rem_sh = {rem_q[REM_W-3:0], src_q[OPND_W-1 -: 2]};
			trial  = REM_W'({res_q[ROOT_W-1:0], 2'b01});
		end else begin
			rem_sh = {rem_q[REM_W-2:0], src_q[OPND_W-1]};
			trial  = REM_W'(dvsr_q);
		end
		fits = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q   <= req.op;
			rem_q  <= '0;
			res_q  <= '0;
			dvsr_q <= dvsr;
			if (req.op == OP_SQRT) begin
				src_q  <= {opnd[PRES_W-1:0], (OPND_W-PRES_W)'(0)};
				step_q <= STEP_W'(SQRT_STEPS);
			end else begin
				src_q  <= opnd;
				step_q <= STEP_W'(DIV_STEPS);
			end
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			res_q  <= {res_q[OPND_W-2:0], fits};
			src_q  <= (op_q == OP_SQRT) ? src_q << 2 : src_q << 1;
			step_q <= step_q - STEP_W'(1);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = res_q;

	`VPFM_ASSERT_NEXT(a_start_busy, clk, arst_n, req.start, stat.busy, "unit not busy after start")
	`VPFM_ASSERT_NOW(a_done_idle, clk, arst_n, stat.done, !stat.busy && !req.start, "done while busy")
	`VPFM_ASSERT_NOW(a_busy_steps, clk, arst_n, busy_q, step_q != '0, "busy with no steps left")
	`VPFM_ASSERT_NOW(a_root_range, clk, arst_n, stat.done && op_q == OP_SQRT, result[OPND_W-1:ROOT_W] == '0, "root too wide")

endmodule

FILE: design/venturi_pressure_flow_meter_unit.sv
// Venturi flow meter top level: frame unpack, pressure, zeroing and flow sequencer.
//
// Each request carries the two leading bytes of a differential pressure frame and a read-ok
// flag; the block returns one result per request. The count is scaled to 1/256 Pa by the
// Q16 pressure_gain (rounded, ties away from zero), then measure requests subtract the stored
// zero offset and saturate to 20 bits; above flow_threshold the flow is the integer root of the
// pressure times cfm_gain / m3h_gain (Q16, rounded, saturated to 16 bits). Zeroing requests
// report the uncorrected pressure and collect good status-0 readings up to ZERO_SAMPLES; a
// commit request loads the truncated average into the zero offset, or raises zero_failed and
// keeps the old one when nothing was collected. One request is in work at a time: the count
// is scaled in the multiplier, rounded, offset-corrected and checked; a flowing measurement
// then takes the square root and the two flow products, and a commit with samples the offset
// division, before the result is loaded into the output register and the next request is
// taken. The time taken is set by the shared compare-subtract unit, which spends 10 steps on
// the square root and 25 on the offset division, plus one pass through the single multiplier
// for each product. A finished result sits in an output register, so the next request is taken
// while it waits; a result still waiting there holds back the loading of the next one.
// Register writes go through at any time and take effect at once.
`include "venturi_pressure_flow_meter_unit_macros.svh"

module venturi_pressure_flow_meter_unit #(
	parameter int ZERO_SAMPLES = vpfm_pkg::ZERO_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vpfm_in_if.sink     sample,
	vpfm_out_if.source  result,
	vpfm_cfg_if.sink    cfg
);
	import vpfm_pkg::*;

	localparam int CNT_W = $clog2(ZERO_SAMPLES + 1);

	// configuration
	logic [COUNT_W-1:0] count_offset_q;
	logic [GAIN_W-1:0]  pressure_gain_q;
	logic [THR_W-1:0]   flow_threshold_q;
	logic [GAIN_W-1:0]  cfm_gain_q;
	logic [GAIN_W-1:0]  m3h_gain_q;

	// zeroing state
	logic signed [PRES_W-1:0] zero_offset_q;
	logic signed [SUM_W-1:0]  zero_sum_q;
	logic [CNT_W-1:0]         zero_cnt_q;

	// sequencer
	state_t state_q;
	state_t state_d;

	// request in work
	logic [ACTION_W-1:0]      action_q;
	logic                     ok_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     neg_q;
	logic [COUNT_W-1:0]       mag_q;
	logic signed [RAW_W-1:0]  raw_q;
	logic signed [PRES_W-1:0] pres_q;
	logic [FLOW_W-1:0]        fc_q;
	logic [FLOW_W-1:0]        fm_q;
	logic                     failed_q;
	logic                     div_neg_q;

	// output register
	logic                     out_valid_q;
	logic                     out_rv_q;
	logic [STATUS_W-1:0]      out_status_q;
	logic signed [PRES_W-1:0] out_pres_q;
	logic [FLOW_W-1:0]        out_fc_q;
	logic [FLOW_W-1:0]        out_fm_q;
	logic                     out_failed_q;

	// shared units
	logic                 mul_start;
	logic [COUNT_W-1:0]   mul_a;
	logic [GAIN_W-1:0]    mul_b;
	logic [RND_W-1:0]     mul_rnd;
	iu_req_t              iu_req;
	iu_stat_t             iu_stat;
	logic [OPND_W-1:0]    iu_opnd;
	logic [OPND_W-1:0]    iu_result;

	// per-state decisions
	logic                     sample_ready;
	logic                     out_load;
	logic [COUNT_W-1:0]       in_count;
	logic [COUNT_W:0]         in_diff;
	logic                     is_sample;
	logic                     is_commit;
	logic                     take_sample;
	logic                     flow_on;
	logic                     cnt_nz;
	logic                     sum_neg;
	logic [SUM_W-1:0]         sum_mag;
	logic [RAW_W-1:0]         rnd_ext;
	logic signed [RAW_W:0]    corr_sub;
	logic [PRES_W-1:0]        quot;

	// frame unpack: status is the top two bits of the high byte, count the rest
	assign in_count = {sample.byte_high[COUNT_W-BYTE_W-1:0], sample.byte_low};
	assign in_diff  = {1'b0, in_count} - {1'b0, count_offset_q};

	assign is_sample   = action_q == ACT_SAMPLE;
	assign is_commit   = action_q == ACT_COMMIT;
	assign take_sample = is_sample && ok_q && status_q == '0 &&
		zero_cnt_q < CNT_W'(ZERO_SAMPLES);
	// threshold is unsigned, so a negative pressure never flows
	assign flow_on = !pres_q[PRES_W-1] && pres_q[PRES_W-2:0] > (PRES_W-1)'(flow_threshold_q);
	assign cnt_nz  = zero_cnt_q != '0;

	// divide magnitudes and fix the sign after, which truncates toward zero
	assign sum_neg = zero_sum_q[SUM_W-1];
	assign sum_mag = sum_neg ? -zero_sum_q : zero_sum_q;
	assign iu_opnd = is_commit ? sum_mag[OPND_W-1:0] : OPND_W'($unsigned(pres_q));
	assign quot    = iu_result[PRES_W-1:0];

	assign rnd_ext  = {1'b0, mul_rnd};
	// zeroing and commit requests report the pressure without the offset
	assign corr_sub = {raw_q[RAW_W-1], raw_q} -
		((is_sample || is_commit) ? '0 : (RAW_W+1)'(zero_offset_q));

	vpfm_mul u_mul (
		.clk   (clk),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.rnd   (mul_rnd)
	);

	vpfm_iu u_iu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (iu_req),
		.opnd   (iu_opnd),
		.dvsr   (CNT_MAX_W'(zero_cnt_q)),
		.stat   (iu_stat),
		.result (iu_result)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sample.valid) begin
					state_d = S_MUL_P;
				end
			end
			S_MUL_P: state_d = S_RAW;
			S_RAW:   state_d = S_PRES;
			S_PRES:  state_d = S_CHECK;
			S_CHECK: begin
				priority if (is_commit) begin
					state_d = cnt_nz ? S_DIV : S_DONE;
				end else if (is_sample) begin
					state_d = S_DONE;
				end else begin
					state_d = flow_on ? S_ROOT : S_DONE;
				end
			end
			S_ROOT: begin
				if (iu_stat.done) begin
					state_d = S_MUL_C;
				end
			end
			S_MUL_C:  state_d = S_MUL_M;
			S_MUL_M:  state_d = S_FLOW_M;
			S_FLOW_M: state_d = S_DONE;
			S_DIV: begin
				if (iu_stat.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample_ready = 1'b0;
		out_load     = 1'b0;
		mul_start    = 1'b0;
		mul_a        = mag_q;
		mul_b        = pressure_gain_q;
		iu_req.start = 1'b0;
		iu_req.op    = OP_SQRT;
		unique case (state_q)
			S_IDLE:  sample_ready = 1'b1;
			S_MUL_P: mul_start = 1'b1;
			S_CHECK: begin
				if (is_commit) begin
					iu_req.start = cnt_nz;
					iu_req.op    = OP_DIV;
				end else if (!is_sample) begin
					iu_req.start = flow_on;
				end
			end
			S_MUL_C: begin
				mul_start = 1'b1;
				mul_a     = COUNT_W'(iu_result[ROOT_W-1:0]);
				mul_b     = cfm_gain_q;
			end
			S_MUL_M: begin
				mul_start = 1'b1;
				mul_a     = COUNT_W'(iu_result[ROOT_W-1:0]);
				mul_b     = m3h_gain_q;
			end
			S_DONE:  out_load = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	// control state, configuration and zeroing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			out_valid_q      <= 1'b0;
			count_offset_q   <= COUNT_OFFSET_RST;
			pressure_gain_q  <= PRESSURE_GAIN_RST;
			flow_threshold_q <= FLOW_THRESHOLD_RST;
			cfm_gain_q       <= CFM_GAIN_RST;
			m3h_gain_q       <= M3H_GAIN_RST;
			zero_offset_q    <= '0;
			zero_sum_q       <= '0;
			zero_cnt_q       <= '0;
		end else begin
			state_q <= state_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				unique case (cfg_idx_t'(cfg.index))
					REG_COUNT_OFFSET:   count_offset_q   <= cfg.data[COUNT_W-1:0];
					REG_PRESSURE_GAIN:  pressure_gain_q  <= cfg.data[GAIN_W-1:0];
					REG_FLOW_THRESHOLD: flow_threshold_q <= cfg.data[THR_W-1:0];
					REG_CFM_GAIN:       cfm_gain_q       <= cfg.data[GAIN_W-1:0];
					REG_M3H_GAIN:       m3h_gain_q       <= cfg.data[GAIN_W-1:0];
					default: ;
				endcase
			end

			// the divider latches sum and count on its start edge, so clearing here is safe
			if (state_q == S_CHECK) begin
				if (take_sample) begin
					zero_sum_q <= zero_sum_q + SUM_W'(pres_q);
					zero_cnt_q <= zero_cnt_q + CNT_W'(1);
				end else if (is_commit) begin
					zero_sum_q <= '0;
					zero_cnt_q <= '0;
				end
			end

			if (state_q == S_DIV && iu_stat.done) begin
				zero_offset_q <= div_neg_q ? -quot : quot;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (sample.valid) begin
					action_q <= sample.action;
					ok_q     <= sample.read_ok;
					status_q <= sample.byte_high[BYTE_W-1 -: STATUS_W];
					neg_q    <= in_diff[COUNT_W];
					mag_q    <= in_diff[COUNT_W] ? COUNT_W'(-in_diff) : in_diff[COUNT_W-1:0];
					fc_q     <= '0;
					fm_q     <= '0;
					failed_q <= 1'b0;
				end
			end
			S_RAW:   raw_q <= neg_q ? -rnd_ext : rnd_ext;
			S_PRES:  pres_q <= sat_pres(corr_sub);
			S_CHECK: begin
				div_neg_q <= sum_neg;
				if (is_commit && !cnt_nz) begin
					failed_q <= 1'b1;
				end
			end
			S_MUL_M:  fc_q <= sat_flow(mul_rnd);
			S_FLOW_M: fm_q <= sat_flow(mul_rnd);
			default: ;
		endcase

		// a failed read reports only its flag and the commit outcome
		if (out_load) begin
			out_rv_q     <= ok_q;
			out_status_q <= ok_q ? status_q : '0;
			out_pres_q   <= ok_q ? pres_q : '0;
			out_fc_q     <= ok_q ? fc_q : '0;
			out_fm_q     <= ok_q ? fm_q : '0;
			out_failed_q <= failed_q;
		end
	end

	assign sample.ready         = sample_ready;
	assign cfg.ready            = 1'b1;
	assign result.valid         = out_valid_q;
	assign result.read_valid    = out_rv_q;
	assign result.sensor_status = out_status_q;
	assign result.pressure      = out_pres_q;
	assign result.flow_cfm      = out_fc_q;
	assign result.flow_m3h      = out_fm_q;
	assign result.zero_failed   = out_failed_q;

	`VPFM_ASSERT_NOW(a_cnt_cap, clk, arst_n, 1'b1, zero_cnt_q <= CNT_W'(ZERO_SAMPLES), "sample count above cap")
	`VPFM_ASSERT_NEXT(a_accept_seq, clk, arst_n, sample.valid && sample.ready, state_q == S_MUL_P, "request not started")
	`VPFM_ASSERT_NOW(a_iu_free, clk, arst_n, iu_req.start, !iu_stat.busy, "shared unit restarted while busy")
	`VPFM_ASSERT_NOW(a_bad_read_quiet, clk, arst_n, result.valid && !result.read_valid, result.pressure == '0 && result.flow_cfm == '0 && result.flow_m3h == '0 && result.sensor_status == '0, "failed read carries data")

endmodule

FILE: tb/tb_venturi_pressure_flow_meter_unit.sv
`timescale 1ns / 100ps
// Testbench of the venturi flow meter: directed and random sensor requests against a predictor.
module tb_venturi_pressure_flow_meter_unit;
	import vpfm_pkg::*;

	// Action code 3 has no package name; the block treats it as a measurement.
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam longint PRES_HI     = (longint'(1) <<< (PRES_W - 1)) - 1;
	localparam longint PRES_LO     = -(longint'(1) <<< (PRES_W - 1));
	localparam longint FLOW_HI     = (longint'(1) <<< FLOW_W) - 1;
	localparam longint HALF_LSB    = longint'(1) <<< (ROUND_SHIFT - 1);
	localparam int     COUNT_HI    = (1 << COUNT_W) - 1;
	localparam int     MAX_REPORTS = 10;
	localparam int     SETTLE_CYC  = 40;
	localparam int     LIMIT_NS    = 5_000_000;

	// One sensor request as it goes onto the input channel.
	typedef struct {
		logic [ACTION_W-1:0] action;
		logic                read_ok;
		logic [BYTE_W-1:0]   byte_high;
		logic [BYTE_W-1:0]   byte_low;
	} frame_req_t;

	// One meter reading as it comes back on the result channel.
	typedef struct {
		logic                     read_valid;
		logic [STATUS_W-1:0]      sensor_status;
		logic signed [PRES_W-1:0] pressure;
		logic [FLOW_W-1:0]        flow_cfm;
		logic [FLOW_W-1:0]        flow_m3h;
		logic                     zero_failed;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;

	vpfm_in_if  sensor_ch();
	vpfm_out_if reading_ch();
	vpfm_cfg_if cfg_ch();

	venturi_pressure_flow_meter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sensor_ch),
		.result (reading_ch),
		.cfg    (cfg_ch)
	);

	// Shadow of the register file, updated when a write is accepted.
	logic [COUNT_W-1:0] offset_cnt = COUNT_OFFSET_RST;
	logic [GAIN_W-1:0]  pres_gain  = PRESSURE_GAIN_RST;
	logic [THR_W-1:0]   flow_thr   = FLOW_THRESHOLD_RST;
	logic [GAIN_W-1:0]  cfm_k      = CFM_GAIN_RST;
	logic [GAIN_W-1:0]  m3h_k      = M3H_GAIN_RST;

	// Zeroing state as the block should hold it.
	int zero_ofs  = 0;
	int zero_acc  = 0;
	int zero_seen = 0;

	frame_req_t frames_pending[$];   // requests waiting for the driver
	reading_t   readings_due[$];     // predicted readings, oldest first

	frame_req_t in_flight;
	reading_t   want_rd;
	int         mismatches = 0;
	int         send_gap;
	int         stall_left;
	bit         drain_hold;
	int         send_idle_pct = 20;
	int         stall_pct = 20;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length: none unless the pct draw picks a gap; then mostly a few cycles, rarely a long stretch.
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct) return 0;
		if ($urandom_range(7) != 0) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic longint clamp_pressure(input longint v);
		if (v > PRES_HI) return PRES_HI;
		if (v < PRES_LO) return PRES_LO;
		return v;
	endfunction

	// Q16 gain on the root, rounded half up, clipped to the flow range.
	function automatic logic [FLOW_W-1:0] scale_flow(input logic [ROOT_W-1:0] root,
		input logic [GAIN_W-1:0] gain);
		longint f;
		f = (longint'(root) * longint'(gain) + HALF_LSB) >>> ROUND_SHIFT;
		if (f > FLOW_HI) return '1;
		return f[FLOW_W-1:0];
	endfunction

	// Expected reading for one accepted request; advances the zeroing state.
	function automatic reading_t predict_reading(input frame_req_t f);
		reading_t            r;
		logic [STATUS_W-1:0] st;
		int                  count;
		int                  diff;
		longint              mag;
		longint              raw;
		longint              rawsat;
		longint              pres;
		logic [ROOT_W-1:0]   root;
		logic [ROOT_W-1:0]   trial;
		r = '{default: 0};
		st = f.byte_high[7:6];
		count = int'({f.byte_high[5:0], f.byte_low});
		diff = count - int'(offset_cnt);
		// rounding is symmetric: work on the magnitude, put the sign back
		mag = longint'(diff < 0 ? -diff : diff) * longint'(pres_gain);
		raw = (mag + HALF_LSB) >>> ROUND_SHIFT;
		if (diff < 0) raw = -raw;
		rawsat = clamp_pressure(raw);
		if (f.action == ACT_SAMPLE || f.action == ACT_COMMIT) begin
			pres = rawsat;
		end else begin
			pres = clamp_pressure(raw - zero_ofs);
			if (pres > longint'(flow_thr)) begin
				// bitwise integer root, msb first
				root = '0;
				for (int b = ROOT_W - 1; b >= 0; b--) begin
					trial = root | (ROOT_W'(1) << b);
					if (PRES_W'(trial) * PRES_W'(trial) <= pres[PRES_W-1:0]) root = trial;
				end
				r.flow_cfm = scale_flow(root, cfm_k);
				r.flow_m3h = scale_flow(root, m3h_k);
			end
		end
		if (f.action == ACT_SAMPLE) begin
			if (f.read_ok && st == '0 && zero_seen < ZERO_SAMPLES_DEF) begin
				zero_acc += int'(rawsat);
				zero_seen++;
			end
		end else if (f.action == ACT_COMMIT) begin
			// int division truncates toward zero
			if (zero_seen > 0) zero_ofs = zero_acc / zero_seen;
			else r.zero_failed = 1'b1;
			zero_acc = 0;
			zero_seen = 0;
		end
		r.read_valid = f.read_ok;
		if (f.read_ok) begin
			r.sensor_status = st;
			r.pressure = pres[PRES_W-1:0];
		end else begin
			r.flow_cfm = '0;
			r.flow_m3h = '0;
		end
		return r;
	endfunction

	function automatic frame_req_t make_req(input logic [ACTION_W-1:0] act, input logic ok,
		input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt);
		frame_req_t f;
		f.action = act;
		f.read_ok = ok;
		f.byte_high = {st, cnt[COUNT_W-1:BYTE_W]};
		f.byte_low = cnt[BYTE_W-1:0];
		return f;
	endfunction

	// Counts cluster around the zero point so the flow threshold gets crossed often.
	function automatic logic [COUNT_W-1:0] pick_count();
		int c;
		if ($urandom_range(2) == 0) begin
			c = int'(offset_cnt) + int'($urandom_range(48)) - 24;
			if (c < 0) c = 0;
			if (c > COUNT_HI) c = COUNT_HI;
			return c[COUNT_W-1:0];
		end
		return COUNT_W'($urandom_range(COUNT_HI));
	endfunction

	function automatic logic [STATUS_W-1:0] pick_status();
		if ($urandom_range(3) == 0) return STATUS_W'($urandom_range(3));
		return '0;
	endfunction

	function automatic logic pick_ok();
		return $urandom_range(9) != 0;
	endfunction

	// Wait until no request is queued or in flight and every reading is back.
	task automatic drain();
		while (frames_pending.size() != 0 || sensor_ch.valid || readings_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_COUNT_OFFSET:   offset_cnt = value[COUNT_W-1:0];
			REG_PRESSURE_GAIN:  pres_gain  = value[GAIN_W-1:0];
			REG_FLOW_THRESHOLD: flow_thr   = value[THR_W-1:0];
			REG_CFM_GAIN:       cfm_k      = value[GAIN_W-1:0];
			REG_M3H_GAIN:       m3h_k      = value[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [CFG_DATA_W-1:0] ofs, input logic [CFG_DATA_W-1:0] pg,
		input logic [CFG_DATA_W-1:0] thr, input logic [CFG_DATA_W-1:0] cg,
		input logic [CFG_DATA_W-1:0] mg);
		write_reg(REG_COUNT_OFFSET, ofs);
		write_reg(REG_PRESSURE_GAIN, pg);
		write_reg(REG_FLOW_THRESHOLD, thr);
		write_reg(REG_CFM_GAIN, cg);
		write_reg(REG_M3H_GAIN, mg);
	endtask

	// One random phase. Most traffic is zeroing runs closed by a commit and followed
	// by measurements; the rest is plain measurement and random noise.
	task automatic run_phase(input int n, input int send_pct, input int stall_p);
		int queued;
		int nsamp;
		int nmeas;
		send_idle_pct = send_pct;
		stall_pct = stall_p;
		queued = 0;
		while (queued < n) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					// now and then run past the sample cap
					nsamp = ($urandom_range(7) == 0) ? $urandom_range(33, 40)
						: $urandom_range(1, 8);
					nmeas = $urandom_range(2, 8);
					repeat (nsamp) frames_pending.push_back(make_req(ACT_SAMPLE, pick_ok(),
						pick_status(), pick_count()));
					frames_pending.push_back(make_req(ACT_COMMIT, pick_ok(), pick_status(),
						pick_count()));
					repeat (nmeas) frames_pending.push_back(make_req(ACT_MEASURE, pick_ok(),
						pick_status(), pick_count()));
					queued += nsamp + nmeas + 1;
				end
				6, 7: begin
					nmeas = $urandom_range(3, 10);
					repeat (nmeas) frames_pending.push_back(make_req(ACT_MEASURE, pick_ok(),
						pick_status(), pick_count()));
					queued += nmeas;
				end
				default: begin
					frames_pending.push_back(make_req(ACTION_W'($urandom_range(3)),
						1'($urandom_range(1)), STATUS_W'($urandom_range(3)),
						COUNT_W'($urandom_range(COUNT_HI))));
					queued++;
				end
			endcase
		end
		drain();
	endtask

	// Request driver: pops the pending queue, predicts on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_ch.valid <= 1'b0;
			send_gap = 0;
			drain_hold = 1'b0;
		end else begin
			if (sensor_ch.valid && sensor_ch.ready) begin
				readings_due.push_back(predict_reading(in_flight));
				// once in a while hold off until every reading is back
				if ($urandom_range(79) == 0) drain_hold = 1'b1;
			end
			if (drain_hold && readings_due.size() == 0) drain_hold = 1'b0;
			if (!sensor_ch.valid || sensor_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					sensor_ch.valid <= 1'b0;
				end else if (drain_hold || frames_pending.size() == 0) begin
					sensor_ch.valid <= 1'b0;
				end else begin
					in_flight = frames_pending.pop_front();
					sensor_ch.valid     <= 1'b1;
					sensor_ch.action    <= in_flight.action;
					sensor_ch.read_ok   <= in_flight.read_ok;
					sensor_ch.byte_high <= in_flight.byte_high;
					sensor_ch.byte_low  <= in_flight.byte_low;
					send_gap = pick_gap(send_idle_pct);
				end
			end
		end
	end

	// Reading monitor: random back-pressure, compares against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (reading_ch.valid && reading_ch.ready) begin
				if (readings_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: reading with no request outstanding", $realtime);
				end else begin
					want_rd = readings_due.pop_front();
					if (want_rd.read_valid !== reading_ch.read_valid ||
						want_rd.sensor_status !== reading_ch.sensor_status ||
						want_rd.pressure !== reading_ch.pressure ||
						want_rd.flow_cfm !== reading_ch.flow_cfm ||
						want_rd.flow_m3h !== reading_ch.flow_m3h ||
						want_rd.zero_failed !== reading_ch.zero_failed) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: reading mismatch", $realtime);
							$display("  expected ok=%0b st=%0d p=%0d cfm=%0d m3h=%0d zf=%0b",
								want_rd.read_valid, want_rd.sensor_status, want_rd.pressure,
								want_rd.flow_cfm, want_rd.flow_m3h, want_rd.zero_failed);
							$display("  got      ok=%0b st=%0d p=%0d cfm=%0d m3h=%0d zf=%0b",
								reading_ch.read_valid, reading_ch.sensor_status,
								reading_ch.pressure, reading_ch.flow_cfm,
								reading_ch.flow_m3h, reading_ch.zero_failed);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				reading_ch.ready <= 1'b0;
			end else begin
				stall_left = pick_gap(stall_pct);
				reading_ch.ready <= (stall_left == 0);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sensor_ch.valid     = 1'b0;
		sensor_ch.action    = ACT_MEASURE;
		sensor_ch.read_ok   = 1'b0;
		sensor_ch.byte_high = '0;
		sensor_ch.byte_low  = '0;
		reading_ch.ready    = 1'b0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_COUNT_OFFSET;
		cfg_ch.data         = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests on reset settings: about 38.9 units of 1/256 Pa per count.
		// Zero point, full scale both ways, just below and just above the threshold.
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd8192));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd16383));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd0));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd8198));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd8199));
		// status bits pass through; all-ones frame bytes
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd3, 14'd16383));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd1, 14'd9000));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd2, 14'd9000));
		// failed read blanks everything; spare action code acts as measure
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b0, 2'd3, 14'd12000));
		frames_pending.push_back(make_req(ACT_SPARE, 1'b1, 2'd0, 14'd12000));
		// commit with nothing collected fails and keeps the offset, read ok or not
		frames_pending.push_back(make_req(ACT_COMMIT, 1'b1, 2'd0, 14'd8300));
		frames_pending.push_back(make_req(ACT_COMMIT, 1'b0, 2'd0, 14'd8300));
		// good samples, then a bad-status one and a failed read that are skipped
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b1, 2'd0, 14'd8300));
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b1, 2'd0, 14'd8400));
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b1, 2'd0, 14'd8500));
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b1, 2'd2, 14'd16383));
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b0, 2'd0, 14'd0));
		frames_pending.push_back(make_req(ACT_COMMIT, 1'b1, 2'd0, 14'd8192));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd8300));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd16383));
		// negative average truncates toward zero; commit on a failed read still applies
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b1, 2'd0, 14'd0));
		frames_pending.push_back(make_req(ACT_SAMPLE, 1'b1, 2'd0, 14'd8193));
		frames_pending.push_back(make_req(ACT_COMMIT, 1'b0, 2'd1, 14'd4000));
		frames_pending.push_back(make_req(ACT_MEASURE, 1'b1, 2'd0, 14'd8192));
		drain();

		run_phase(90, 20, 20);

		// Upper extremes: pressure saturates, flows clip.
		write_all(24'd16383, 24'hFFFFFF, 24'd65535, 24'hFFFFFF, 24'hFFFFFF);
		run_phase(70, 0, 0);

		// Lower extremes: zero gains, zero threshold.
		write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
		run_phase(60, 40, 40);

		// Realistic span with unsaturated flows.
		write_all(24'd8192, CFG_DATA_W'($urandom_range(20000, 200000)),
			CFG_DATA_W'($urandom_range(512)), CFG_DATA_W'($urandom_range(1 << 16, 1 << 22)),
			CFG_DATA_W'($urandom_range(1 << 16, 1 << 22)));
		run_phase(100, 25, 50);

		// Arbitrary data, upper bits of the narrow registers included.
		write_all(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
			CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
		run_phase(100, 50, 10);

		write_all(CFG_DATA_W'(COUNT_OFFSET_RST), CFG_DATA_W'(PRESSURE_GAIN_RST),
			CFG_DATA_W'(FLOW_THRESHOLD_RST), CFG_DATA_W'(CFM_GAIN_RST),
			CFG_DATA_W'(M3H_GAIN_RST));
		run_phase(100, 10, 60);

		repeat (SETTLE_CYC) @(posedge clk);
		if (mismatches == 0 && readings_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: a lost reading or a hung handshake ends here.
	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
